// ----- design/sgs_pkg.sv -----
// ----------------------------------------------------------------------------
// sgs_pkg
// Shared widths, codes and control types of the scattered group sampler.
// ----------------------------------------------------------------------------
package sgs_pkg;

    // fixed field widths of the request and result beats
    localparam int GROUP_BITS = 4;
    localparam int WVAL_BITS  = 24;
    localparam int FRAC_BITS  = 24;
    localparam int CFG_BITS   = 5;

    // active group count after reset
    localparam int CFG_GROUPS_RST = 16;

    // step counter for the shift-add multiply, one fraction bit per cycle
    localparam int MC_W = $clog2(FRAC_BITS);

    // request kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // per-cycle command to the shared arithmetic unit
    typedef struct packed {
        logic load;       // clear accumulators, capture fraction
        logic acc_total;  // total += weight
        logic mul_step;   // product += total if fraction bit set; shift
        logic acc_run;    // running sum += weight, compare
    } t_dp_ctrl;

endpackage

// ----- design/sgs_ifs.sv -----
// ----------------------------------------------------------------------------
// sgs_req_if / sgs_res_if
// Valid/ready channels for sampler requests and sampled groups.
// ----------------------------------------------------------------------------
interface sgs_req_if;
    import sgs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [GROUP_BITS-1:0] source_group;
    logic [GROUP_BITS-1:0] target_group;
    logic [WVAL_BITS-1:0]  weight_value;
    logic [FRAC_BITS-1:0]  random_fraction;

    modport source (
        output valid, kind, source_group, target_group, weight_value, random_fraction,
        input  ready
    );
    modport sink (
        input  valid, kind, source_group, target_group, weight_value, random_fraction,
        output ready
    );
endinterface

interface sgs_res_if;
    import sgs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [GROUP_BITS-1:0] sampled_group;
    logic                  fell_through;

    modport source (
        output valid, sampled_group, fell_through,
        input  ready
    );
    modport sink (
        input  valid, sampled_group, fell_through,
        output ready
    );
endinterface

// ----- design/sgs_wmem.sv -----
// ----------------------------------------------------------------------------
// sgs_wmem
// Weight table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sgs_wmem #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 24
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);
    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- design/sgs_arith.sv -----
// ----------------------------------------------------------------------------
// sgs_arith
// Shared adder with total, product and running-sum registers.
// ----------------------------------------------------------------------------
module sgs_arith #(
    parameter int WEIGHT_BITS = 24,
    parameter int SUM_W       = 28
) (
    input  logic                     i_clk,
    input  sgs_pkg::t_dp_ctrl        i_ctrl,
    input  logic [sgs_pkg::FRAC_BITS-1:0] i_frac,
    input  logic [WEIGHT_BITS-1:0]   i_weight,
    output logic                     o_hit
);
    import sgs_pkg::*;

    localparam int PROD_W = SUM_W + FRAC_BITS;

    logic [PROD_W-1:0]    r_total;
    logic [PROD_W-1:0]    r_prod;
    logic [SUM_W-1:0]     r_run;
    logic [FRAC_BITS-1:0] r_frac;

    logic [PROD_W-1:0] opa;
    logic [PROD_W-1:0] opb;
    logic [PROD_W-1:0] sum;

    // one adder serves all three passes
    always_comb begin
        opa = PROD_W'(r_run);
        opb = PROD_W'(i_weight);
        if (i_ctrl.acc_total) begin
            opa = r_total;
        end else if (i_ctrl.mul_step) begin
            opa = r_prod;
            opb = r_total;
        end
        sum = opa + opb;
    end

    // frac * total < run * 2^FRAC_BITS, exact
    assign o_hit = r_prod < {sum[SUM_W-1:0], {FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_total <= '0;
            r_prod  <= '0;
            r_run   <= '0;
            r_frac  <= i_frac;
        end else if (i_ctrl.acc_total) begin
            r_total <= sum;
        end else if (i_ctrl.mul_step) begin
            if (r_frac[0]) begin
                r_prod <= sum;
            end
            r_total <= r_total << 1;
            r_frac  <= r_frac >> 1;
        end else if (i_ctrl.acc_run) begin
            r_run <= sum[SUM_W-1:0];
        end
    end
endmodule

// ----- design/scattered_group_sampler.sv -----
// ----------------------------------------------------------------------------
// scattered_group_sampler
// Inverse-CDF sampling of the post-scatter energy group from a weight table.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries two kinds of beat. A write beat stores one weight at
//   (source_group, target_group) and gives no result.
//   A sample beat picks the row of source_group and returns one beat on
//   o_res: the first group whose running sum exceeds fraction * row total,
//   or the last active group with fell_through set when none does.
//   i_cfg_wr_en / i_cfg_wr_data set the active group count; write it only
//   while no sample is in flight.
// Sequence:
//   From accept to o_res.valid a sample runs, with N the active group
//   count, one row pass through the table read port for the total, a
//   shift-add pass over the fraction bits on the shared adder for the
//   product, and a second row pass that stops at the first hit.
//   i_req.ready is low while a sample is being worked on, so a sample
//   holds the input until its result is taken into the output register.
// Reset and stall:
//   Reset clears the sequencer and the output valid and sets N to 16,
//   capped at MAX_GROUPS; the table is not cleared. A finished result
//   waits in the output register; write beats and a new sample are still
//   accepted meanwhile, and that next sample holds its result until the register frees.
// ----------------------------------------------------------------------------
module scattered_group_sampler #(
    parameter int MAX_GROUPS  = 16,
    parameter int WEIGHT_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [sgs_pkg::CFG_BITS-1:0] i_cfg_wr_data,
    sgs_req_if.sink                      i_req,
    sgs_res_if.source                    o_res
);
    import sgs_pkg::*;

    localparam int GIDX_W   = $clog2(MAX_GROUPS);
    localparam int SUM_W    = WEIGHT_BITS + GIDX_W;
    localparam int RST_LAST =
        ((CFG_GROUPS_RST > MAX_GROUPS) ? MAX_GROUPS : CFG_GROUPS_RST) - 1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SUM  = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_FIN  = 5'b10000
    } t_state;

    t_state                r_state,     n_state;
    logic [GIDX_W-1:0]     r_last,      n_last;
    logic [GIDX_W-1:0]     r_row,       n_row;
    logic                  r_row_ok,    n_row_ok;
    logic [GIDX_W-1:0]     r_col,       n_col;
    logic                  r_issue,     n_issue;
    logic                  r_dv,        n_dv;
    logic                  r_dlast,     n_dlast;
    logic [GIDX_W-1:0]     r_dcol,      n_dcol;
    logic [MC_W-1:0]       r_mcnt,      n_mcnt;
    logic [GIDX_W-1:0]     r_res_grp,   n_res_grp;
    logic                  r_res_ft,    n_res_ft;
    logic                  r_ovalid,    n_ovalid;
    logic [GROUP_BITS-1:0] r_ogroup,    n_ogroup;
    logic                  r_oft,       n_oft;

    logic [GIDX_W+GROUP_BITS-1:0]  src_ext;
    logic [GIDX_W+GROUP_BITS-1:0]  dst_ext;
    logic [GIDX_W+GROUP_BITS-1:0]  res_ext;
    logic [GIDX_W+GROUP_BITS-1:0]  last_ext;
    logic [WEIGHT_BITS+WVAL_BITS-1:0] wval_ext;
    logic                          src_ok;
    logic                          dst_ok;
    logic                          req_acc;
    logic                          mem_we;
    logic [WEIGHT_BITS-1:0]        rd_data;
    logic [WEIGHT_BITS-1:0]        weight;
    logic                          hit;
    logic [31:0]                   cfg_n;
    t_dp_ctrl                      ctrl;

    assign src_ext  = (GIDX_W+GROUP_BITS)'(i_req.source_group);
    assign dst_ext  = (GIDX_W+GROUP_BITS)'(i_req.target_group);
    assign res_ext  = (GIDX_W+GROUP_BITS)'(r_res_grp);
    assign last_ext = (GIDX_W+GROUP_BITS)'(r_last);
    assign wval_ext = (WEIGHT_BITS+WVAL_BITS)'(i_req.weight_value);
    assign src_ok   = 32'(i_req.source_group) < MAX_GROUPS;
    assign dst_ok   = 32'(i_req.target_group) < MAX_GROUPS;

    assign i_req.ready = i_rst_n && (r_state == ST_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign mem_we      = req_acc && (i_req.kind == KIND_WRITE) && src_ok && dst_ok;

    // rows beyond the table read as zero
    assign weight = r_row_ok ? rd_data : '0;

    sgs_wmem #(
        .ADDR_W (2 * GIDX_W),
        .DATA_W (WEIGHT_BITS)
    ) u_wmem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr ({src_ext[GIDX_W-1:0], dst_ext[GIDX_W-1:0]}),
        .i_wr_data (wval_ext[WEIGHT_BITS-1:0]),
        .i_rd_addr ({r_row, r_col}),
        .o_rd_data (rd_data)
    );

    sgs_arith #(
        .WEIGHT_BITS (WEIGHT_BITS),
        .SUM_W       (SUM_W)
    ) u_arith (
        .i_clk    (i_clk),
        .i_ctrl   (ctrl),
        .i_frac   (i_req.random_fraction),
        .i_weight (weight),
        .o_hit    (hit)
    );

    // clamp active groups to 1..MAX_GROUPS, keep the last index
    always_comb begin
        cfg_n = 32'(i_cfg_wr_data);
        if (cfg_n == 32'd0) begin
            cfg_n = 32'd1;
        end else if (cfg_n > 32'(MAX_GROUPS)) begin
            cfg_n = 32'(MAX_GROUPS);
        end
        n_last = i_cfg_wr_en ? GIDX_W'(cfg_n - 32'd1) : r_last;
    end

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_row_ok  = r_row_ok;
        n_col     = r_col;
        n_issue   = r_issue;
        n_dv      = 1'b0;
        n_dlast   = 1'b0;
        n_dcol    = r_col;
        n_mcnt    = r_mcnt;
        n_res_grp = r_res_grp;
        n_res_ft  = r_res_ft;
        n_ovalid  = r_ovalid && !o_res.ready;
        n_ogroup  = r_ogroup;
        n_oft     = r_oft;
        ctrl      = '0;

        case (r_state)
            ST_IDLE: begin
                if (req_acc && (i_req.kind == KIND_SAMPLE)) begin
                    ctrl.load = 1'b1;
                    n_row     = src_ext[GIDX_W-1:0];
                    n_row_ok  = src_ok;
                    n_col     = '0;
                    n_issue   = 1'b1;
                    n_state   = ST_SUM;
                end
            end
            ST_SUM, ST_SCAN: begin
                // each read is issued in the cycle before its data returns
                if (r_issue) begin
                    n_dv    = 1'b1;
                    n_dlast = (r_col == r_last);
                    if (r_col == r_last) begin
                        n_issue = 1'b0;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
                if (r_state == ST_SUM) begin
                    ctrl.acc_total = r_dv;
                    if (r_dv && r_dlast) begin
                        n_mcnt  = '0;
                        n_state = ST_MUL;
                    end
                end else begin
                    ctrl.acc_run = r_dv;
                    if (r_dv && (hit || r_dlast)) begin
                        n_res_grp = hit ? r_dcol : r_last;
                        n_res_ft  = !hit;
                        n_issue   = 1'b0;
                        n_dv      = 1'b0;
                        n_state   = ST_FIN;
                    end
                end
            end
            ST_MUL: begin
                ctrl.mul_step = 1'b1;
                n_mcnt        = r_mcnt + 1'b1;
                if (r_mcnt == MC_W'(FRAC_BITS - 1)) begin
                    n_col   = '0;
                    n_issue = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_FIN: begin
                if (!r_ovalid || o_res.ready) begin
                    n_ovalid = 1'b1;
                    n_ogroup = res_ext[GROUP_BITS-1:0];
                    n_oft    = r_res_ft;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_last   <= GIDX_W'(RST_LAST);
            r_issue  <= 1'b0;
            r_dv     <= 1'b0;
            r_dlast  <= 1'b0;
            r_mcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_last   <= n_last;
            r_issue  <= n_issue;
            r_dv     <= n_dv;
            r_dlast  <= n_dlast;
            r_mcnt   <= n_mcnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row     <= n_row;
        r_row_ok  <= n_row_ok;
        r_col     <= n_col;
        r_dcol    <= n_dcol;
        r_res_grp <= n_res_grp;
        r_res_ft  <= n_res_ft;
        r_ogroup  <= n_ogroup;
        r_oft     <= n_oft;
    end

    assign o_res.valid         = r_ovalid;
    assign o_res.sampled_group = r_ogroup;
    assign o_res.fell_through  = r_oft;

    // a new result beat only comes out of the finish step
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == ST_FIN))
        else $error("result beat raised outside finish step");

    // returned data never belongs to a column past the active range
    a_dcol_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_dcol <= r_last))
        else $error("table data beyond active groups");

    // fall-through returns the last active group
    a_ft_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oft) |-> (r_ogroup == last_ext[GROUP_BITS-1:0]))
        else $error("fall-through group is not the last active group");

    // multiply pass is left after exactly FRAC_BITS steps
    a_mul_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL && r_mcnt == MC_W'(FRAC_BITS - 1)) |=> (r_state == ST_SCAN))
        else $error("multiply pass length wrong");

    // no table read is in flight once the scan has resolved
    a_fin_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> (!r_issue && !r_dv))
        else $error("table read still in flight at finish");
endmodule
